// ===== rtl/iac_pkg.sv =====
// shared types and constants for the intruder alarm controller
package iac_pkg;

    // alarm modes, as shown on the status channel
    localparam logic [2:0] MODE_DISARMED  = 3'd0;
    localparam logic [2:0] MODE_ARMING    = 3'd1;
    localparam logic [2:0] MODE_ARMED     = 3'd2;
    localparam logic [2:0] MODE_TRIGGERED = 3'd3;
    localparam logic [2:0] MODE_SIREN     = 3'd4;

    // commands carried with a tick
    localparam logic [2:0] CMD_TICK          = 3'd0;
    localparam logic [2:0] CMD_KEY           = 3'd1;
    localparam logic [2:0] CMD_ARM           = 3'd2;
    localparam logic [2:0] CMD_FORCE_DISARM  = 3'd3;
    localparam logic [2:0] CMD_REMOTE_DISARM = 3'd4;

    // siren tones: off, low and high
    localparam logic [1:0] TONE_OFF  = 2'd0;
    localparam logic [1:0] TONE_LOW  = 2'd1;
    localparam logic [1:0] TONE_HIGH = 2'd2;

    // trigger causes
    localparam logic [1:0] CAUSE_NONE   = 2'd0;
    localparam logic [1:0] CAUSE_MOTION = 2'd1;
    localparam logic [1:0] CAUSE_BEAM   = 2'd2;
    localparam logic [1:0] CAUSE_CODES  = 2'd3;

    // configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 22;
    localparam logic [CFG_INDEX_W-1:0] REG_CODE_DIGITS   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_WRONG     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_TIMEOUT   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_EXIT_DELAY    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_DELAY   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SIREN_MAX     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_MOTION_WARMUP = 3'd6;

    // field widths
    localparam int CODE_W  = 16;
    localparam int WRONG_W = 8;
    localparam int DELAY_W = 22;
    localparam int BEEP_W  = 9;
    localparam int FLIP_W  = 9;
    localparam int PHASE_W = 10;

    // timing constants in milliseconds, and the wrong-code ceiling
    localparam logic [FLIP_W-1:0]  FLIP_MAX     = 9'd511;
    localparam logic [FLIP_W-1:0]  TONE_FLIP_MS = 9'd350;
    localparam logic [BEEP_W-1:0]  BEEP_KEY     = 9'd30;
    localparam logic [BEEP_W-1:0]  BEEP_GOOD    = 9'd80;
    localparam logic [BEEP_W-1:0]  BEEP_BAD     = 9'd400;
    localparam logic [BEEP_W-1:0]  BEEP_CHIRP   = 9'd25;
    localparam logic [PHASE_W-1:0] CHIRP_WINDOW = 10'd30;
    localparam logic [PHASE_W-1:0] EXIT_PERIOD  = 10'd1000;
    localparam logic [PHASE_W-1:0] ENTRY_PERIOD = 10'd500;
    localparam logic [WRONG_W-1:0] WRONG_MAX    = 8'd255;

    // reset values of the configuration registers
    localparam logic [CODE_W-1:0]  RST_CODE_DIGITS   = 16'd4660;
    localparam logic [WRONG_W-1:0] RST_MAX_WRONG     = 8'd3;
    localparam logic [DELAY_W-1:0] RST_KEY_TIMEOUT   = 22'd5000;
    localparam logic [DELAY_W-1:0] RST_EXIT_DELAY    = 22'd30000;
    localparam logic [DELAY_W-1:0] RST_ENTRY_DELAY   = 22'd15000;
    localparam logic [DELAY_W-1:0] RST_SIREN_MAX     = 22'd180000;
    localparam logic [DELAY_W-1:0] RST_MOTION_WARMUP = 22'd30000;

    // configuration as seen by the controller
    typedef struct packed {
        logic [CODE_W-1:0]  code_digits;
        logic [WRONG_W-1:0] max_wrong_codes;
        logic [DELAY_W-1:0] key_timeout_ms;
        logic [DELAY_W-1:0] exit_delay_ms;
        logic [DELAY_W-1:0] entry_delay_ms;
        logic [DELAY_W-1:0] siren_max_ms;
        logic [DELAY_W-1:0] motion_warmup_ms;
    } cfg_t;

endpackage

// ===== rtl/iac_if.sv =====
// channel interfaces: tick items, status results and configuration writes
interface iac_tick_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [3:0]  key_value;
    logic [15:0] remote_code;
    logic [3:0]  remote_count;
    logic        motion_raw;
    logic        beam_raw;

    modport source (output valid, command, key_value, remote_code, remote_count,
                    motion_raw, beam_raw, input ready);
    modport sink (input valid, command, key_value, remote_code, remote_count,
                  motion_raw, beam_raw, output ready);
endinterface

interface iac_status_if;
    logic       valid;
    logic       ready;
    logic [2:0] alarm_mode;
    logic       chirp_on;
    logic [1:0] tone_select;
    logic [7:0] wrong_count;
    logic [1:0] trigger_cause;
    logic       siren_started;
    logic       remote_ok;

    modport source (output valid, alarm_mode, chirp_on, tone_select, wrong_count,
                    trigger_cause, siren_started, remote_ok, input ready);
    modport sink (input valid, alarm_mode, chirp_on, tone_select, wrong_count,
                  trigger_cause, siren_started, remote_ok, output ready);
endinterface

interface iac_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [iac_pkg::CFG_INDEX_W-1:0]     index;
    logic [iac_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/iac_cfg_regs.sv =====
// configuration register file with reset defaults
module iac_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    iac_cfg_if.sink       cfg,
    output iac_pkg::cfg_t settings
);

    iac_pkg::cfg_t settings_reg;
    iac_pkg::cfg_t settings_next;
    logic          write_en;

    // writes are always taken
    assign cfg.ready = 1'b1;
    assign write_en  = cfg.valid;
    assign settings  = settings_reg;

    // register decode
    always_comb
    begin
        settings_next = settings_reg;
        if (write_en)
        begin
            case (cfg.index)
                iac_pkg::REG_CODE_DIGITS:
                    settings_next.code_digits = cfg.data[iac_pkg::CODE_W-1:0];
                iac_pkg::REG_MAX_WRONG:
                    settings_next.max_wrong_codes = cfg.data[iac_pkg::WRONG_W-1:0];
                iac_pkg::REG_KEY_TIMEOUT:
                    settings_next.key_timeout_ms = cfg.data;
                iac_pkg::REG_EXIT_DELAY:
                    settings_next.exit_delay_ms = cfg.data;
                iac_pkg::REG_ENTRY_DELAY:
                    settings_next.entry_delay_ms = cfg.data;
                iac_pkg::REG_SIREN_MAX:
                    settings_next.siren_max_ms = cfg.data;
                iac_pkg::REG_MOTION_WARMUP:
                    settings_next.motion_warmup_ms = cfg.data;
                default:
                    settings_next = settings_reg;
            endcase
        end
    end

    // register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settings_reg.code_digits      <= iac_pkg::RST_CODE_DIGITS;
            settings_reg.max_wrong_codes  <= iac_pkg::RST_MAX_WRONG;
            settings_reg.key_timeout_ms   <= iac_pkg::RST_KEY_TIMEOUT;
            settings_reg.exit_delay_ms    <= iac_pkg::RST_EXIT_DELAY;
            settings_reg.entry_delay_ms   <= iac_pkg::RST_ENTRY_DELAY;
            settings_reg.siren_max_ms     <= iac_pkg::RST_SIREN_MAX;
            settings_reg.motion_warmup_ms <= iac_pkg::RST_MOTION_WARMUP;
        end
        else
        begin
            settings_reg <= settings_next;
        end
    end

endmodule

// ===== rtl/intruder_alarm_controller.sv =====
// intruder alarm controller: one tick item per millisecond, one status result per tick
//
// tick channel: each transaction is one millisecond tick carrying the sensor levels
// and an optional command (key digit, arm, force disarm, remote disarm with code).
// the command is applied first, then the millisecond passes and the mode logic runs.
// status channel: one transaction per tick with mode, buzzer, tone, wrong-code count,
// trigger cause and the siren-entry and remote-accept pulses.
// cfg channel: register writes, always ready, applied at the clock edge of the write.
// timing: the status for a tick is registered and is valid in the cycle after the tick is accepted.
// throughput: one tick per cycle while the status receiver is ready; the whole update sits
// between the state registers and the status output register.
// stall: the status register holds its result while the receiver is not ready; a new
// tick is taken in the same cycle the held result leaves.
// reset: disarmed, timers cleared, tone silent, tone flip timer saturated,
// configuration back to its defaults; the key buffer holds no valid digits.
module intruder_alarm_controller #(
    parameter int CODE_DIGITS = 4,
    parameter int TIMER_BITS  = 22
) (
    input  logic        clk,
    input  logic        rst_n,
    iac_tick_if.sink    tick,
    iac_status_if.source status,
    iac_cfg_if.sink     cfg
);

    localparam int DIGIT_W = 4 * CODE_DIGITS;
    localparam int KC_W    = $clog2(CODE_DIGITS + 1);
    localparam int CMP_W   = (TIMER_BITS > iac_pkg::DELAY_W) ? TIMER_BITS : iac_pkg::DELAY_W;

    iac_pkg::cfg_t settings;

    // state
    logic [2:0]                  mode_reg, mode_next;
    logic [TIMER_BITS-1:0]       time_reg, time_next;
    logic [iac_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [3:0]                  key_buf_reg [CODE_DIGITS];
    logic [KC_W-1:0]             kc_reg, kc_next;
    logic [TIMER_BITS-1:0]       slk_reg, slk_next;
    logic [iac_pkg::FLIP_W-1:0]  flip_reg, flip_next;
    logic                        flag_reg, flag_next;
    logic [1:0]                  tone_reg, tone_next;
    logic [iac_pkg::BEEP_W-1:0]  beep_reg, beep_next;
    logic [iac_pkg::WRONG_W-1:0] wrong_reg, wrong_next;
    logic [1:0]                  cause_reg, cause_next;
    logic [TIMER_BITS-1:0]       uptime_reg, uptime_next;

    // output register
    logic                        out_valid_reg, out_valid_next;
    logic [2:0]                  out_mode_reg;
    logic                        out_chirp_reg;
    logic [1:0]                  out_tone_reg;
    logic [iac_pkg::WRONG_W-1:0] out_wrong_reg;
    logic [1:0]                  out_cause_reg;
    logic                        out_siren_reg;
    logic                        out_remote_reg;

    // per-tick working signals
    logic                        accept;
    logic                        siren_pulse;
    logic                        remote_good;
    logic [KC_W-1:0]             kc_eff;
    logic [CODE_DIGITS-1:0]      key_we;
    logic [DIGIT_W-1:0]          buf_word;
    logic [DIGIT_W-1:0]          code_word;
    logic [DIGIT_W-1:0]          remote_word;
    logic [31:0]                 code_wide;
    logic [31:0]                 remote_wide;
    logic                        motion_hit;
    logic                        beam_hit;
    logic [iac_pkg::PHASE_W-1:0] entry_phase;

    iac_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .settings (settings)
    );

    // handshake
    assign tick.ready = !out_valid_reg || status.ready;
    assign accept     = tick.valid && tick.ready;

    // codes as digit words, first digit in the top nibble
    assign code_wide   = {16'b0, settings.code_digits};
    assign remote_wide = {16'b0, tick.remote_code};
    assign code_word   = code_wide[DIGIT_W-1:0];
    assign remote_word = remote_wide[DIGIT_W-1:0];

    // next state for one tick
    always_comb
    begin
        mode_next   = mode_reg;
        time_next   = time_reg;
        phase_next  = phase_reg;
        kc_next     = kc_reg;
        slk_next    = slk_reg;
        flip_next   = flip_reg;
        flag_next   = flag_reg;
        tone_next   = tone_reg;
        beep_next   = beep_reg;
        wrong_next  = wrong_reg;
        cause_next  = cause_reg;
        uptime_next = uptime_reg;
        siren_pulse = 1'b0;
        remote_good = 1'b0;
        kc_eff      = kc_reg;
        key_we      = '0;
        motion_hit  = 1'b0;
        beam_hit    = 1'b0;
        entry_phase = '0;

        // key inactivity clears the buffer
        if (CMP_W'(slk_reg) > CMP_W'(settings.key_timeout_ms))
        begin
            kc_eff = '0;
        end
        for (int i = 0; i < CODE_DIGITS; i++)
        begin
            key_we[i] = (tick.command == iac_pkg::CMD_KEY) && (kc_eff == KC_W'(i));
            buf_word[4*(CODE_DIGITS-1-i) +: 4] = key_we[i] ? tick.key_value : key_buf_reg[i];
        end

        // command at the current time
        case (tick.command)
            iac_pkg::CMD_KEY:
            begin
                slk_next  = '0;
                kc_next   = kc_eff + KC_W'(1);
                beep_next = iac_pkg::BEEP_KEY;
                if (kc_next == KC_W'(CODE_DIGITS))
                begin
                    kc_next = '0;
                    if (buf_word == code_word)
                    begin
                        wrong_next = '0;
                        mode_next  = iac_pkg::MODE_DISARMED;
                        time_next  = '0;
                        phase_next = '0;
                        tone_next  = iac_pkg::TONE_OFF;
                        beep_next  = iac_pkg::BEEP_GOOD;
                    end
                    else
                    begin
                        if (wrong_reg != iac_pkg::WRONG_MAX)
                        begin
                            wrong_next = wrong_reg + iac_pkg::WRONG_W'(1);
                        end
                        beep_next = iac_pkg::BEEP_BAD;
                        if (wrong_next >= settings.max_wrong_codes &&
                            (mode_reg == iac_pkg::MODE_ARMED ||
                             mode_reg == iac_pkg::MODE_TRIGGERED))
                        begin
                            cause_next  = iac_pkg::CAUSE_CODES;
                            mode_next   = iac_pkg::MODE_SIREN;
                            time_next   = '0;
                            phase_next  = '0;
                            siren_pulse = 1'b1;
                        end
                    end
                end
            end
            iac_pkg::CMD_ARM:
            begin
                if (mode_reg == iac_pkg::MODE_DISARMED)
                begin
                    mode_next  = iac_pkg::MODE_ARMING;
                    time_next  = '0;
                    phase_next = '0;
                    tone_next  = iac_pkg::TONE_OFF;
                end
            end
            iac_pkg::CMD_FORCE_DISARM:
            begin
                wrong_next = '0;
                kc_next    = '0;
                mode_next  = iac_pkg::MODE_DISARMED;
                time_next  = '0;
                phase_next = '0;
                tone_next  = iac_pkg::TONE_OFF;
            end
            iac_pkg::CMD_REMOTE_DISARM:
            begin
                if (tick.remote_count == 4'(CODE_DIGITS) && remote_word == code_word)
                begin
                    remote_good = 1'b1;
                    wrong_next  = '0;
                    kc_next     = '0;
                    mode_next   = iac_pkg::MODE_DISARMED;
                    time_next   = '0;
                    phase_next  = '0;
                    tone_next   = iac_pkg::TONE_OFF;
                end
            end
            default:
            begin
                kc_next = kc_reg;
            end
        endcase

        // one millisecond passes; the chirp phase follows the mode timer modulo 1000
        if (!(&time_next))
        begin
            time_next  = time_next + TIMER_BITS'(1);
            phase_next = (phase_next == iac_pkg::EXIT_PERIOD - iac_pkg::PHASE_W'(1)) ?
                         '0 : phase_next + iac_pkg::PHASE_W'(1);
        end
        if (!(&uptime_reg))
        begin
            uptime_next = uptime_reg + TIMER_BITS'(1);
        end
        if (!(&slk_next))
        begin
            slk_next = slk_next + TIMER_BITS'(1);
        end
        if (flip_reg != iac_pkg::FLIP_MAX)
        begin
            flip_next = flip_reg + iac_pkg::FLIP_W'(1);
        end
        if (beep_next != '0)
        begin
            beep_next = beep_next - iac_pkg::BEEP_W'(1);
        end

        // sensors
        motion_hit = (CMP_W'(uptime_next) > CMP_W'(settings.motion_warmup_ms)) &&
                     tick.motion_raw;
        beam_hit   = !tick.beam_raw;
        entry_phase = (phase_next >= iac_pkg::ENTRY_PERIOD) ?
                      phase_next - iac_pkg::ENTRY_PERIOD : phase_next;

        // mode logic
        case (mode_next)
            iac_pkg::MODE_ARMING:
            begin
                if (phase_next < iac_pkg::CHIRP_WINDOW && beep_next == '0)
                begin
                    beep_next = iac_pkg::BEEP_CHIRP;
                end
                if (CMP_W'(time_next) >= CMP_W'(settings.exit_delay_ms))
                begin
                    mode_next  = iac_pkg::MODE_ARMED;
                    time_next  = '0;
                    phase_next = '0;
                    tone_next  = iac_pkg::TONE_OFF;
                end
            end
            iac_pkg::MODE_ARMED:
            begin
                if (motion_hit || beam_hit)
                begin
                    cause_next = motion_hit ? iac_pkg::CAUSE_MOTION : iac_pkg::CAUSE_BEAM;
                    mode_next  = iac_pkg::MODE_TRIGGERED;
                    time_next  = '0;
                    phase_next = '0;
                    tone_next  = iac_pkg::TONE_OFF;
                end
            end
            iac_pkg::MODE_TRIGGERED:
            begin
                if (entry_phase < iac_pkg::CHIRP_WINDOW && beep_next == '0)
                begin
                    beep_next = iac_pkg::BEEP_CHIRP;
                end
                if (CMP_W'(time_next) >= CMP_W'(settings.entry_delay_ms))
                begin
                    mode_next   = iac_pkg::MODE_SIREN;
                    time_next   = '0;
                    phase_next  = '0;
                    siren_pulse = 1'b1;
                end
            end
            iac_pkg::MODE_SIREN:
            begin
                if (flip_next >= iac_pkg::TONE_FLIP_MS)
                begin
                    flip_next = '0;
                    flag_next = !flag_reg;
                    tone_next = flag_next ? iac_pkg::TONE_HIGH : iac_pkg::TONE_LOW;
                end
                if (CMP_W'(time_next) >= CMP_W'(settings.siren_max_ms))
                begin
                    mode_next  = iac_pkg::MODE_ARMED;
                    time_next  = '0;
                    phase_next = '0;
                    tone_next  = iac_pkg::TONE_OFF;
                end
            end
            default:
            begin
                tone_next = tone_next;
            end
        endcase
    end

    // status register moves on when the receiver takes it
    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (status.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= iac_pkg::MODE_DISARMED;
            time_reg      <= '0;
            phase_reg     <= '0;
            kc_reg        <= '0;
            slk_reg       <= '0;
            flip_reg      <= iac_pkg::FLIP_MAX;
            flag_reg      <= 1'b0;
            tone_reg      <= iac_pkg::TONE_OFF;
            beep_reg      <= '0;
            wrong_reg     <= '0;
            cause_reg     <= iac_pkg::CAUSE_NONE;
            uptime_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                mode_reg   <= mode_next;
                time_reg   <= time_next;
                phase_reg  <= phase_next;
                kc_reg     <= kc_next;
                slk_reg    <= slk_next;
                flip_reg   <= flip_next;
                flag_reg   <= flag_next;
                tone_reg   <= tone_next;
                beep_reg   <= beep_next;
                wrong_reg  <= wrong_next;
                cause_reg  <= cause_next;
                uptime_reg <= uptime_next;
            end
        end
    end

    // key buffer and status payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < CODE_DIGITS; i++)
            begin
                if (key_we[i])
                begin
                    key_buf_reg[i] <= tick.key_value;
                end
            end
            out_mode_reg   <= mode_next;
            out_chirp_reg  <= (beep_next != '0);
            out_tone_reg   <= tone_next;
            out_wrong_reg  <= wrong_next;
            out_cause_reg  <= cause_next;
            out_siren_reg  <= siren_pulse;
            out_remote_reg <= remote_good;
        end
    end

    assign status.valid         = out_valid_reg;
    assign status.alarm_mode    = out_mode_reg;
    assign status.chirp_on      = out_chirp_reg;
    assign status.tone_select   = out_tone_reg;
    assign status.wrong_count   = out_wrong_reg;
    assign status.trigger_cause = out_cause_reg;
    assign status.siren_started = out_siren_reg;
    assign status.remote_ok     = out_remote_reg;

endmodule

// ===== rtl/iac_checker.sv =====
// port-level checks for the intruder alarm controller, bound to the top level
module iac_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       tick_valid,
    input logic       tick_ready,
    input logic       status_valid,
    input logic       status_ready,
    input logic [2:0] alarm_mode,
    input logic [1:0] tone_select,
    input logic [7:0] wrong_count,
    input logic [1:0] trigger_cause,
    input logic       siren_started,
    input logic       remote_ok
);

    // a stalled status transaction holds its mode
    assert property (@(posedge clk) disable iff (!rst_n)
        status_valid && !status_ready |=> status_valid && $stable(alarm_mode))
        else $error("status transaction dropped or changed while stalled");

    // every accepted tick yields a status transaction next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && tick_ready |=> status_valid)
        else $error("no status after accepted tick");

    // a siren tone only sounds in siren mode
    assert property (@(posedge clk) disable iff (!rst_n)
        status_valid && tone_select != iac_pkg::TONE_OFF |->
        alarm_mode == iac_pkg::MODE_SIREN)
        else $error("tone outside siren mode");

    // accepted remote disarm leaves the system disarmed with no wrong codes
    assert property (@(posedge clk) disable iff (!rst_n)
        status_valid && remote_ok |->
        alarm_mode == iac_pkg::MODE_DISARMED && wrong_count == 8'd0)
        else $error("remote disarm did not disarm");

    // siren entry always has a recorded cause
    assert property (@(posedge clk) disable iff (!rst_n)
        status_valid && siren_started |-> trigger_cause != iac_pkg::CAUSE_NONE)
        else $error("siren entered without cause");

endmodule

bind intruder_alarm_controller iac_checker u_iac_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .tick_valid    (tick.valid),
    .tick_ready    (tick.ready),
    .status_valid  (status.valid),
    .status_ready  (status.ready),
    .alarm_mode    (status.alarm_mode),
    .tone_select   (status.tone_select),
    .wrong_count   (status.wrong_count),
    .trigger_cause (status.trigger_cause),
    .siren_started (status.siren_started),
    .remote_ok     (status.remote_ok)
);

// ===== sim/intruder_alarm_controller_test.sv =====
// self-checking testbench for the intruder alarm controller: directed table, then random phases
module intruder_alarm_controller_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIGITS      = 4;
    localparam int IDLE_PCT    = 37;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 60;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SOAK_PHASE  = 2;
    localparam int PHASES      = 4;

    // command values with no function, taken as a plain tick
    localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
    localparam logic [2:0] CMD_SPARE_MID = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI  = 3'd7;

    localparam logic [iac_pkg::DELAY_W-1:0] DELAY_MAX = '1;

    typedef struct packed {
        logic [2:0]  command;
        logic [3:0]  key_value;
        logic [15:0] remote_code;
        logic [3:0]  remote_count;
        logic        motion_raw;
        logic        beam_raw;
    } tick_t;

    typedef struct packed {
        logic [2:0] alarm_mode;
        logic       chirp_on;
        logic [1:0] tone_select;
        logic [7:0] wrong_count;
        logic [1:0] trigger_cause;
        logic       siren_started;
        logic       remote_ok;
    } status_t;

    typedef enum {ROW_TICK, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t                       kind;
        tick_t                           item;
        logic [iac_pkg::CFG_INDEX_W-1:0] reg_index;
        logic [iac_pkg::CFG_DATA_W-1:0]  reg_data;
        bit                              typed;
        status_t                         want;
    } step_row_t;

    logic clk;
    logic rst_n;

    iac_tick_if   tick_ch ();
    iac_status_if status_ch ();
    iac_cfg_if    cfg_ch ();

    intruder_alarm_controller DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_ch),
        .status (status_ch),
        .cfg    (cfg_ch)
    );

    // shadow of the controller state and configuration
    iac_pkg::cfg_t               shadow;
    logic [2:0]                  mode;
    logic [iac_pkg::DELAY_W-1:0] time_in_mode;
    logic [3:0]                  key_buf [DIGITS];
    int                          key_cnt;
    logic [iac_pkg::DELAY_W-1:0] since_key;
    logic [iac_pkg::FLIP_W-1:0]  flip_timer;
    logic                        tone_hi;
    logic [1:0]                  tone;
    logic [iac_pkg::BEEP_W-1:0]  beep;
    logic [iac_pkg::WRONG_W-1:0] wrong;
    logic [1:0]                  cause;
    logic [iac_pkg::DELAY_W-1:0] uptime;
    logic                        siren_pulse;

    status_t   pending_status [$];
    step_row_t plan [$];
    int        failures;
    int        results_seen;
    int        cycle_count;
    bit        steady;

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // run limit
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("intruder_alarm_controller test failed");
            $finish;
        end
    end

    function automatic logic [iac_pkg::DELAY_W-1:0] sat_inc(
        input logic [iac_pkg::DELAY_W-1:0] x);
        return (x == DELAY_MAX) ? x : x + iac_pkg::DELAY_W'(1);
    endfunction

    task automatic enter_mode(input logic [2:0] m);
        mode = m;
        time_in_mode = '0;
        if (m == iac_pkg::MODE_SIREN)
            siren_pulse = 1'b1;
        else
            tone = iac_pkg::TONE_OFF;
    endtask

    task automatic disarm_all();
        wrong = '0;
        key_cnt = 0;
        enter_mode(iac_pkg::MODE_DISARMED);
    endtask

    // full key buffer: compare with the code, then clear
    task automatic judge_code();
        if (key_cnt < DIGITS)
            return;
        key_cnt = 0;
        if ({key_buf[0], key_buf[1], key_buf[2], key_buf[3]} == shadow.code_digits)
        begin
            wrong = '0;
            enter_mode(iac_pkg::MODE_DISARMED);
            beep = iac_pkg::BEEP_GOOD;
        end
        else
        begin
            if (wrong != iac_pkg::WRONG_MAX)
                wrong++;
            beep = iac_pkg::BEEP_BAD;
            if (wrong >= shadow.max_wrong_codes &&
                (mode == iac_pkg::MODE_ARMED || mode == iac_pkg::MODE_TRIGGERED))
            begin
                cause = iac_pkg::CAUSE_CODES;
                enter_mode(iac_pkg::MODE_SIREN);
            end
        end
    endtask

    // one millisecond of controller behaviour: command first, then the tick
    task automatic next_status(input tick_t t, output status_t s);
        logic motion;
        logic beam;
        logic remote_hit;
        siren_pulse = 1'b0;
        remote_hit = 1'b0;
        case (t.command)
            iac_pkg::CMD_KEY:
            begin
                if (since_key > shadow.key_timeout_ms)
                    key_cnt = 0;
                since_key = '0;
                if (key_cnt < DIGITS)
                begin
                    key_buf[key_cnt] = t.key_value;
                    key_cnt++;
                end
                beep = iac_pkg::BEEP_KEY;
                judge_code();
            end
            iac_pkg::CMD_ARM:
                if (mode == iac_pkg::MODE_DISARMED)
                    enter_mode(iac_pkg::MODE_ARMING);
            iac_pkg::CMD_FORCE_DISARM:
                disarm_all();
            iac_pkg::CMD_REMOTE_DISARM:
                if (t.remote_count == 4'(DIGITS) && t.remote_code == shadow.code_digits)
                begin
                    disarm_all();
                    remote_hit = 1'b1;
                end
            default: ;
        endcase

        uptime = sat_inc(uptime);
        time_in_mode = sat_inc(time_in_mode);
        since_key = sat_inc(since_key);
        if (flip_timer < iac_pkg::FLIP_MAX)
            flip_timer++;
        if (beep != '0)
            beep--;

        motion = (uptime > shadow.motion_warmup_ms) && t.motion_raw;
        beam = !t.beam_raw;

        case (mode)
            iac_pkg::MODE_ARMING:
            begin
                if ((time_in_mode % iac_pkg::DELAY_W'(iac_pkg::EXIT_PERIOD)) <
                    iac_pkg::DELAY_W'(iac_pkg::CHIRP_WINDOW) && beep == '0)
                    beep = iac_pkg::BEEP_CHIRP;
                if (time_in_mode >= shadow.exit_delay_ms)
                    enter_mode(iac_pkg::MODE_ARMED);
            end
            iac_pkg::MODE_ARMED:
                if (motion)
                begin
                    cause = iac_pkg::CAUSE_MOTION;
                    enter_mode(iac_pkg::MODE_TRIGGERED);
                end
                else if (beam)
                begin
                    cause = iac_pkg::CAUSE_BEAM;
                    enter_mode(iac_pkg::MODE_TRIGGERED);
                end
            iac_pkg::MODE_TRIGGERED:
            begin
                if ((time_in_mode % iac_pkg::DELAY_W'(iac_pkg::ENTRY_PERIOD)) <
                    iac_pkg::DELAY_W'(iac_pkg::CHIRP_WINDOW) && beep == '0)
                    beep = iac_pkg::BEEP_CHIRP;
                if (time_in_mode >= shadow.entry_delay_ms)
                    enter_mode(iac_pkg::MODE_SIREN);
            end
            iac_pkg::MODE_SIREN:
            begin
                if (flip_timer >= iac_pkg::TONE_FLIP_MS)
                begin
                    flip_timer = '0;
                    tone_hi = !tone_hi;
                    tone = tone_hi ? iac_pkg::TONE_HIGH : iac_pkg::TONE_LOW;
                end
                if (time_in_mode >= shadow.siren_max_ms)
                    enter_mode(iac_pkg::MODE_ARMED);
            end
            default: ;
        endcase

        s.alarm_mode    = mode;
        s.chirp_on      = (beep != '0);
        s.tone_select   = tone;
        s.wrong_count   = wrong;
        s.trigger_cause = cause;
        s.siren_started = siren_pulse;
        s.remote_ok     = remote_hit;
    endtask

    task automatic apply_setting(input logic [iac_pkg::CFG_INDEX_W-1:0] idx,
                                 input logic [iac_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            iac_pkg::REG_CODE_DIGITS:   shadow.code_digits = data[iac_pkg::CODE_W-1:0];
            iac_pkg::REG_MAX_WRONG:     shadow.max_wrong_codes = data[iac_pkg::WRONG_W-1:0];
            iac_pkg::REG_KEY_TIMEOUT:   shadow.key_timeout_ms = data;
            iac_pkg::REG_EXIT_DELAY:    shadow.exit_delay_ms = data;
            iac_pkg::REG_ENTRY_DELAY:   shadow.entry_delay_ms = data;
            iac_pkg::REG_SIREN_MAX:     shadow.siren_max_ms = data;
            iac_pkg::REG_MOTION_WARMUP: shadow.motion_warmup_ms = data;
            default: ;
        endcase
    endtask

    // one register write transaction
    task automatic write_reg(input logic [iac_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [iac_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        apply_setting(idx, data);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic load_settings(input iac_pkg::cfg_t c);
        write_reg(iac_pkg::REG_CODE_DIGITS, iac_pkg::CFG_DATA_W'(c.code_digits));
        write_reg(iac_pkg::REG_MAX_WRONG, iac_pkg::CFG_DATA_W'(c.max_wrong_codes));
        write_reg(iac_pkg::REG_KEY_TIMEOUT, c.key_timeout_ms);
        write_reg(iac_pkg::REG_EXIT_DELAY, c.exit_delay_ms);
        write_reg(iac_pkg::REG_ENTRY_DELAY, c.entry_delay_ms);
        write_reg(iac_pkg::REG_SIREN_MAX, c.siren_max_ms);
        write_reg(iac_pkg::REG_MOTION_WARMUP, c.motion_warmup_ms);
    endtask

    // offer one tick transaction, with random gaps, and record its expected status
    task automatic send_tick(input tick_t t, input bit typed, input status_t want);
        status_t s;
        @(negedge clk);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            tick_ch.valid <= 1'b0;
            @(negedge clk);
        end
        tick_ch.valid        <= 1'b1;
        tick_ch.command      <= t.command;
        tick_ch.key_value    <= t.key_value;
        tick_ch.remote_code  <= t.remote_code;
        tick_ch.remote_count <= t.remote_count;
        tick_ch.motion_raw   <= t.motion_raw;
        tick_ch.beam_raw     <= t.beam_raw;
        @(posedge clk);
        while (!tick_ch.ready)
            @(posedge clk);
        next_status(t, s);
        pending_status.push_back(typed ? want : s);
    endtask

    // stop offering and wait until every expected status has arrived
    task automatic drain();
        @(negedge clk);
        tick_ch.valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
    endtask

    function automatic step_row_t row_tick(input logic [2:0] cmd, input logic [3:0] key,
                                           input logic [15:0] code, input logic [3:0] cnt,
                                           input logic mot, input logic bm);
        step_row_t r;
        r.kind      = ROW_TICK;
        r.item      = '{cmd, key, code, cnt, mot, bm};
        r.reg_index = '0;
        r.reg_data  = '0;
        r.typed     = 1'b0;
        r.want      = '0;
        return r;
    endfunction

    function automatic step_row_t row_typed(input step_row_t r, input status_t s);
        step_row_t t;
        t = r;
        t.typed = 1'b1;
        t.want  = s;
        return t;
    endfunction

    function automatic step_row_t row_write(input logic [iac_pkg::CFG_INDEX_W-1:0] idx,
                                            input logic [iac_pkg::CFG_DATA_W-1:0] data);
        step_row_t r;
        r = row_tick(iac_pkg::CMD_TICK, '0, '0, '0, 1'b0, 1'b1);
        r.kind      = ROW_WRITE;
        r.reg_index = idx;
        r.reg_data  = data;
        return r;
    endfunction

    // settings of each random phase, extremes included
    function automatic iac_pkg::cfg_t phase_settings(input int phase);
        iac_pkg::cfg_t c;
        case (phase)
            0: c = '{16'($urandom_range(16'hffff)), 8'd2, 22'd40, 22'd20, 22'd25,
                     22'd60, 22'd150};
            1: c = '{16'h0000, 8'd1, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0};
            SOAK_PHASE:
               c = '{16'hffff, 8'd255, DELAY_MAX, 22'd5, 22'd5, 22'd500, DELAY_MAX};
            default:
               c = '{16'($urandom_range(16'hffff)), 8'd1, DELAY_MAX, DELAY_MAX, DELAY_MAX,
                     DELAY_MAX, DELAY_MAX};
        endcase
        return c;
    endfunction

    function automatic int phase_length(input int phase);
        case (phase)
            0:          return 200;
            1:          return 120;
            SOAK_PHASE: return 1150;
            default:    return 120;
        endcase
    endfunction

    // random tick: mostly well-formed key and remote sequences, some noise
    function automatic tick_t draw_tick(input int phase);
        tick_t t;
        int unsigned r;
        t.command      = iac_pkg::CMD_TICK;
        t.key_value    = 4'($urandom_range(15));
        t.remote_code  = 16'($urandom_range(16'hffff));
        t.remote_count = 4'($urandom_range(15));
        t.motion_raw   = ($urandom_range(99) < 8);
        t.beam_raw     = ($urandom_range(99) >= 6);
        r = $urandom_range(99);
        if (phase == SOAK_PHASE)
        begin
            // key storm with no disarm: wrong count saturates, siren runs its full time
            if (r < 93)
                t.command = iac_pkg::CMD_KEY;
            else if (r < 94)
                t.command = iac_pkg::CMD_ARM;
            else if (r < 96)
                t.command = CMD_SPARE_LO + 3'($urandom_range(2));
        end
        else if (r < 30)
        begin
            t.command = iac_pkg::CMD_KEY;
            if (key_cnt < DIGITS && $urandom_range(99) < 75)
                t.key_value = shadow.code_digits[iac_pkg::CODE_W-1-4*key_cnt -: 4];
        end
        else if (r < 38)
            t.command = iac_pkg::CMD_ARM;
        else if (r < 42)
            t.command = iac_pkg::CMD_FORCE_DISARM;
        else if (r < 52)
        begin
            t.command = iac_pkg::CMD_REMOTE_DISARM;
            if ($urandom_range(99) < 60)
            begin
                t.remote_code  = shadow.code_digits;
                t.remote_count = 4'(DIGITS);
            end
            else if ($urandom_range(1) == 1)
                t.remote_count = 4'(DIGITS);
        end
        else if (r < 55)
            t.command = CMD_SPARE_LO + 3'($urandom_range(2));
        return t;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endtask

    // compare one status transaction with the oldest expectation
    task automatic check_status();
        status_t want;
        if (pending_status.size() == 0)
        begin
            $error("status transaction with no expectation waiting");
            failures++;
            return;
        end
        want = pending_status.pop_front();
        check_field("alarm_mode", 32'(want.alarm_mode), 32'(status_ch.alarm_mode));
        check_field("chirp_on", 32'(want.chirp_on), 32'(status_ch.chirp_on));
        check_field("tone_select", 32'(want.tone_select), 32'(status_ch.tone_select));
        check_field("wrong_count", 32'(want.wrong_count), 32'(status_ch.wrong_count));
        check_field("trigger_cause", 32'(want.trigger_cause),
                    32'(status_ch.trigger_cause));
        check_field("siren_started", 32'(want.siren_started),
                    32'(status_ch.siren_started));
        check_field("remote_ok", 32'(want.remote_ok), 32'(status_ch.remote_ok));
    endtask

    // status receiver: random back-pressure, one long hold-off
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        results_seen = 0;
        status_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (results_seen >= HOLD_AT && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                status_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                status_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            @(posedge clk);
            if (rst_n === 1'b1 && status_ch.valid === 1'b1 && status_ch.ready === 1'b1)
            begin
                check_status();
                results_seen++;
            end
        end
    end

    // stimulus
    initial
    begin
        status_t none;
        status_t s;
        iac_pkg::cfg_t c;
        failures = 0;
        steady = 1'b0;
        rst_n = 1'b0;
        tick_ch.valid        = 1'b0;
        tick_ch.command      = iac_pkg::CMD_TICK;
        tick_ch.key_value    = '0;
        tick_ch.remote_code  = '0;
        tick_ch.remote_count = '0;
        tick_ch.motion_raw   = 1'b0;
        tick_ch.beam_raw     = 1'b1;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = iac_pkg::REG_CODE_DIGITS;
        cfg_ch.data  = '0;

        // state after reset
        shadow = '{iac_pkg::RST_CODE_DIGITS, iac_pkg::RST_MAX_WRONG,
                   iac_pkg::RST_KEY_TIMEOUT, iac_pkg::RST_EXIT_DELAY,
                   iac_pkg::RST_ENTRY_DELAY, iac_pkg::RST_SIREN_MAX,
                   iac_pkg::RST_MOTION_WARMUP};
        mode = iac_pkg::MODE_DISARMED;
        time_in_mode = '0;
        foreach (key_buf[i])
            key_buf[i] = '0;
        key_cnt = 0;
        since_key = '0;
        flip_timer = iac_pkg::FLIP_MAX;
        tone_hi = 1'b0;
        tone = iac_pkg::TONE_OFF;
        beep = '0;
        wrong = '0;
        cause = iac_pkg::CAUSE_NONE;
        uptime = '0;
        siren_pulse = 1'b0;
        none = '0;

        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed rows, default settings first
        plan.push_back(row_typed(row_tick(iac_pkg::CMD_TICK, 4'd0, 16'h0000, 4'd0,
            1'b1, 1'b1), '{iac_pkg::MODE_DISARMED, 1'b0, iac_pkg::TONE_OFF, 8'd0,
            iac_pkg::CAUSE_NONE, 1'b0, 1'b0}));
        plan.push_back(row_typed(row_tick(iac_pkg::CMD_KEY, 4'd1, 16'h0000, 4'd0,
            1'b0, 1'b1), '{iac_pkg::MODE_DISARMED, 1'b1, iac_pkg::TONE_OFF, 8'd0,
            iac_pkg::CAUSE_NONE, 1'b0, 1'b0}));
        plan.push_back(row_tick(iac_pkg::CMD_KEY, 4'd2, 16'h0000, 4'd0, 1'b0, 1'b1));
        plan.push_back(row_tick(iac_pkg::CMD_KEY, 4'd3, 16'h0000, 4'd0, 1'b0, 1'b1));
        plan.push_back(row_typed(row_tick(iac_pkg::CMD_KEY, 4'd4, 16'h0000, 4'd0,
            1'b0, 1'b1), '{iac_pkg::MODE_DISARMED, 1'b1, iac_pkg::TONE_OFF, 8'd0,
            iac_pkg::CAUSE_NONE, 1'b0, 1'b0}));
        // wrong entry, the buffer is judged as soon as it is full
        plan.push_back(row_tick(iac_pkg::CMD_KEY, 4'd15, 16'h0000, 4'd0, 1'b0, 1'b1));
        plan.push_back(row_tick(iac_pkg::CMD_KEY, 4'd15, 16'h0000, 4'd0, 1'b0, 1'b1));
        plan.push_back(row_tick(iac_pkg::CMD_KEY, 4'd15, 16'h0000, 4'd0, 1'b0, 1'b1));
        plan.push_back(row_typed(row_tick(iac_pkg::CMD_KEY, 4'd15, 16'h0000, 4'd0,
            1'b0, 1'b1), '{iac_pkg::MODE_DISARMED, 1'b1, iac_pkg::TONE_OFF, 8'd1,
            iac_pkg::CAUSE_NONE, 1'b0, 1'b0}));
        plan.push_back(row_tick(iac_pkg::CMD_KEY, 4'd0, 16'h0000, 4'd0, 1'b0, 1'b1));
        // remote disarm: short count, wrong code, then good
        plan.push_back(row_typed(row_tick(iac_pkg::CMD_REMOTE_DISARM, 4'd0,
            iac_pkg::RST_CODE_DIGITS, 4'd3, 1'b0, 1'b1), '{iac_pkg::MODE_DISARMED,
            1'b1, iac_pkg::TONE_OFF, 8'd1, iac_pkg::CAUSE_NONE, 1'b0, 1'b0}));
        plan.push_back(row_tick(iac_pkg::CMD_REMOTE_DISARM, 4'd15, 16'hffff, 4'd15,
            1'b0, 1'b0));
        plan.push_back(row_typed(row_tick(iac_pkg::CMD_REMOTE_DISARM, 4'd0,
            iac_pkg::RST_CODE_DIGITS, 4'd4, 1'b0, 1'b1), '{iac_pkg::MODE_DISARMED,
            1'b1, iac_pkg::TONE_OFF, 8'd0, iac_pkg::CAUSE_NONE, 1'b0, 1'b1}));
        plan.push_back(row_tick(iac_pkg::CMD_REMOTE_DISARM, 4'd0, 16'h0000, 4'd4,
            1'b1, 1'b0));
        // unused commands act as a plain tick
        plan.push_back(row_tick(CMD_SPARE_LO, 4'd9, 16'h5a5a, 4'd4, 1'b0, 1'b1));
        plan.push_back(row_tick(CMD_SPARE_MID, 4'd6, 16'ha5a5, 4'd4, 1'b1, 1'b1));
        plan.push_back(row_tick(CMD_SPARE_HI, 4'd15, 16'hffff, 4'd15, 1'b1, 1'b0));
        // disarm while already disarmed
        plan.push_back(row_tick(iac_pkg::CMD_FORCE_DISARM, 4'd0, 16'h0000, 4'd0,
            1'b0, 1'b1));
        // short delays: walk through every mode
        plan.push_back(row_write(iac_pkg::REG_EXIT_DELAY, 22'd2));
        plan.push_back(row_write(iac_pkg::REG_ENTRY_DELAY, 22'd3));
        plan.push_back(row_write(iac_pkg::REG_SIREN_MAX, 22'd1));
        plan.push_back(row_write(iac_pkg::REG_MAX_WRONG, 22'd1));
        plan.push_back(row_write(iac_pkg::REG_MOTION_WARMUP, 22'd0));
        plan.push_back(row_tick(iac_pkg::CMD_ARM, 4'd0, 16'h0000, 4'd0, 1'b0, 1'b1));
        plan.push_back(row_tick(iac_pkg::CMD_TICK, 4'd0, 16'h0000, 4'd0, 1'b0, 1'b1));
        plan.push_back(row_tick(iac_pkg::CMD_TICK, 4'd0, 16'h0000, 4'd0, 1'b0, 1'b0));
        plan.push_back(row_tick(iac_pkg::CMD_TICK, 4'd0, 16'h0000, 4'd0, 1'b1, 1'b1));
        plan.push_back(row_tick(iac_pkg::CMD_TICK, 4'd0, 16'h0000, 4'd0, 1'b0, 1'b1));
        plan.push_back(row_tick(iac_pkg::CMD_TICK, 4'd0, 16'h0000, 4'd0, 1'b0, 1'b1));
        plan.push_back(row_tick(iac_pkg::CMD_ARM, 4'd0, 16'h0000, 4'd0, 1'b1, 1'b1));

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                drain();
                write_reg(plan[i].reg_index, plan[i].reg_data);
            end
            else
                send_tick(plan[i].item, plan[i].typed, plan[i].want);
        end

        // random phases, each under its own settings
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain();
            c = phase_settings(phase);
            load_settings(c);
            for (int n = 0; n < phase_length(phase); n++)
            begin
                steady = (phase == SOAK_PHASE && n >= 300 && n < 600);
                if (phase == 0 && n == 100)
                    drain();
                send_tick(draw_tick(phase), 1'b0, none);
            end
            steady = 1'b0;
        end

        drain();
        repeat (3)
            @(posedge clk);
        if (failures == 0)
            $display("intruder_alarm_controller test passed");
        else
            $display("intruder_alarm_controller test failed");
        $finish;
    end

endmodule
